FILE: rtl/rrip_pkg.sv
// Shared types and constants for the RRIP replacement block.
package rrip_pkg;

  typedef enum logic [2:0] {
    CMD_HIT   = 3'd0,
    CMD_FILL  = 3'd1,
    CMD_EVICT = 3'd2,
    CMD_INVAL = 3'd3,
    CMD_QUERY = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_t;

  typedef enum logic {
    REG_PERIOD = 1'b0,
    REG_LONG   = 1'b1
  } reg_idx_t;

  localparam logic [6:0] PERIOD_RESET = 7'd64;
  localparam logic [6:0] LONG_RESET   = 7'd1;
  localparam logic [6:0] PERIOD_MAX   = 7'd64;
  localparam logic [6:0] PERIOD_MIN   = 7'd1;

  typedef struct packed {
    logic clr_en;
    logic capture;
    logic exec;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic out_block;
  } dp_sts_t;

endpackage

FILE: rtl/rrip_ctrl.sv
// Controller state machine: clearing pass, item accept and row update sequencing.
module rrip_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_stall,
  input  rrip_pkg::dp_sts_t   sts,
  output rrip_pkg::ctrl_cmd_t cmd
);
  import rrip_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (sts.clr_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (item_valid) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        if (!sts.out_block) state_next = ST_IDLE;
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    item_stall  = 1'b1;
    cmd.clr_en  = 1'b0;
    cmd.capture = 1'b0;
    cmd.exec    = 1'b0;
    case (state)
      ST_CLEAR: begin
        cmd.clr_en = 1'b1;
      end
      ST_IDLE: begin
        item_stall  = 1'b0;
        cmd.capture = item_valid;
      end
      ST_EXEC: begin
        cmd.exec = !sts.out_block;
      end
      default: ;
    endcase
  end

endmodule

FILE: rtl/rrip_dp.sv
// Datapath: prediction memory, row update and victim search, fill pattern, registers.
module rrip_dp #(
  parameter int SETS      = 64,
  parameter int WAYS      = 16,
  parameter int PRED_BITS = 3
) (
  input  logic                clk,
  input  logic                rst,
  input  rrip_pkg::ctrl_cmd_t cmd,
  output rrip_pkg::dp_sts_t   sts,
  input  logic [2:0]          command,
  input  logic [5:0]          set_index,
  input  logic [3:0]          way,
  output logic                result_valid,
  input  logic                result_stall,
  output logic [3:0]          victim_way,
  output logic                victim_valid,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata
);
  import rrip_pkg::*;

  localparam int SET_AW = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int ROW_W  = WAYS * PRED_BITS;
  localparam logic [PRED_BITS-1:0] DISTANT = {PRED_BITS{1'b1}};
  localparam logic [PRED_BITS-1:0] LONG    = DISTANT - PRED_BITS'(1);

  logic [ROW_W-1:0]  mem [SETS];
  logic [ROW_W-1:0]  rd_row;
  logic [SET_AW-1:0] clr_cnt;

  logic [2:0]        cur_cmd;
  logic [3:0]        cur_way;
  logic [SET_AW-1:0] cur_addr;
  logic              cur_set_ok;
  logic              cur_way_ok;

  logic [SET_AW+5:0] addr_ext;
  logic [SET_AW-1:0] item_addr;
  logic              item_set_ok;
  logic              item_way_ok;

  logic [6:0] insert_period;
  logic [6:0] long_per_period;
  logic [5:0] miss_pos;
  logic [6:0] long_cnt;

  logic [6:0]  eff_p;
  logic [6:0]  eff_l;
  logic [6:0]  mp_inc;
  logic [13:0] prod_a;
  logic [13:0] prod_b;
  logic        fill_long;
  logic [PRED_BITS-1:0] fill_val;
  logic        fill_adv;

  logic [PRED_BITS-1:0] vals [WAYS];
  logic [PRED_BITS-1:0] sel_val;
  logic [PRED_BITS-1:0] age_d;
  logic [ROW_W-1:0]     new_row;
  logic [WAYS-1:0]      cand;
  logic [WAYS-1:0]      col;
  logic [3:0]           best;
  logic                 row_we;
  logic                 is_query;
  logic                 cfg_we;

  // Item decode.
  assign addr_ext    = {{SET_AW{1'b0}}, set_index};
  assign item_addr   = addr_ext[SET_AW-1:0];
  assign item_set_ok = 32'(set_index) < SETS;
  assign item_way_ok = item_set_ok && (32'(way) < WAYS);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cur_cmd    <= command;
      cur_way    <= way;
      cur_addr   <= item_addr;
      cur_set_ok <= item_set_ok;
      cur_way_ok <= item_way_ok;
    end
  end

  // Clearing pass counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clr_en) begin
      clr_cnt <= clr_cnt + SET_AW'(1);
    end
  end

  assign sts.clr_last = (clr_cnt == SET_AW'(SETS - 1));

  // Prediction memory, one row of all ways per set.
  always_ff @(posedge clk) begin
    if (cmd.clr_en) begin
      mem[clr_cnt] <= {WAYS{DISTANT}};
    end else if (row_we) begin
      mem[cur_addr] <= new_row;
    end
    if (cmd.capture) begin
      rd_row <= mem[item_addr];
    end
  end

  // Insertion pattern.
  always_comb begin
    if (insert_period == 7'd0) begin
      eff_p = PERIOD_MIN;
    end else if (insert_period > PERIOD_MAX) begin
      eff_p = PERIOD_MAX;
    end else begin
      eff_p = insert_period;
    end
    eff_l = (long_per_period > PERIOD_MAX) ? PERIOD_MAX : long_per_period;
  end

  assign mp_inc    = {1'b0, miss_pos} + 7'd1;
  assign prod_a    = 14'(mp_inc) * 14'(eff_l);
  assign prod_b    = 14'(long_cnt) * 14'(eff_p);
  assign fill_long = prod_a > prod_b;
  assign fill_val  = fill_long ? LONG : DISTANT;
  assign fill_adv  = cmd.exec && cur_way_ok && (cur_cmd == CMD_FILL);
  assign cfg_we    = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      insert_period   <= PERIOD_RESET;
      long_per_period <= LONG_RESET;
      miss_pos        <= '0;
      long_cnt        <= '0;
    end else if (cfg_we) begin
      case (reg_idx_t'(paddr[2]))
        REG_PERIOD: insert_period   <= pwdata[6:0];
        REG_LONG:   long_per_period <= pwdata[6:0];
        default: ;
      endcase
      miss_pos <= '0;
      long_cnt <= '0;
    end else if (fill_adv) begin
      if (mp_inc >= eff_p) begin
        miss_pos <= '0;
        long_cnt <= '0;
      end else begin
        miss_pos <= mp_inc[5:0];
        long_cnt <= fill_long ? long_cnt + 7'd1 : long_cnt;
      end
    end
  end

  assign prdata = (reg_idx_t'(paddr[2]) == REG_LONG) ? 32'(long_per_period)
                                                     : 32'(insert_period);

  // Row update.
  always_comb begin
    sel_val = '0;
    for (int k = 0; k < WAYS; k++) begin
      vals[k] = rd_row[k*PRED_BITS +: PRED_BITS];
      if (k == int'(cur_way)) sel_val = sel_val | vals[k];
    end
  end

  assign age_d = DISTANT - sel_val;

  always_comb begin
    logic [PRED_BITS:0]   sum;
    logic [PRED_BITS-1:0] v;
    new_row = rd_row;
    for (int k = 0; k < WAYS; k++) begin
      v   = vals[k];
      sum = {1'b0, vals[k]} + {1'b0, age_d};
      case (cur_cmd)
        CMD_HIT:   if (k == int'(cur_way)) v = '0;
        CMD_FILL:  if (k == int'(cur_way)) v = fill_val;
        CMD_INVAL: if (k == int'(cur_way)) v = DISTANT;
        CMD_EVICT: v = sum[PRED_BITS] ? DISTANT : sum[PRED_BITS-1:0];
        default: ;
      endcase
      new_row[k*PRED_BITS +: PRED_BITS] = v;
    end
  end

  always_comb begin
    case (cur_cmd)
      CMD_HIT, CMD_FILL, CMD_EVICT, CMD_INVAL: row_we = cmd.exec && cur_way_ok;
      default: row_we = 1'b0;
    endcase
  end

  // The first way that holds the maximum is also the first distant way when one exists.
  always_comb begin
    cand = '1;
    col  = '0;
    for (int b = PRED_BITS - 1; b >= 0; b--) begin
      for (int k = 0; k < WAYS; k++) begin
        col[k] = vals[k][b];
      end
      if (|(cand & col)) cand = cand & col;
    end
    best = '0;
    for (int k = WAYS - 1; k >= 0; k--) begin
      if (cand[k]) best = 4'(k);
    end
  end

  assign is_query = (cur_cmd == CMD_QUERY);

  // Result register.
  assign sts.out_block = result_valid && result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.exec) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      victim_valid <= is_query;
      victim_way   <= (is_query && cur_set_ok) ? best : 4'd0;
    end
  end

endmodule

FILE: rtl/rrip_cache_replacement_top.sv
// Top level of the RRIP cache replacement block.
// Each item is one replacement event and gives one result item. The accept state reads the
// set's row from the prediction memory; the execute state then updates or searches all ways
// of the row at once, writes an updated row back and loads the result register; that
// single-port read-modify-write of one row sets the rate. If the previous result is still
// stalled at that point the item waits in the execute state until it is taken. After reset the
// block clears the memory one set per cycle, with item_stall high.
module rrip_cache_replacement_top #(
  parameter int SETS      = 64,
  parameter int WAYS      = 16,
  parameter int PRED_BITS = 3
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic [2:0]  command,
  input  logic [5:0]  set_index,
  input  logic [3:0]  way,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [3:0]  victim_way,
  output logic        victim_valid,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import rrip_pkg::*;

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  assign pready = 1'b1;

  rrip_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .sts        (sts),
    .cmd        (cmd)
  );

  rrip_dp #(
    .SETS      (SETS),
    .WAYS      (WAYS),
    .PRED_BITS (PRED_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .command      (command),
    .set_index    (set_index),
    .way          (way),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .victim_way   (victim_way),
    .victim_valid (victim_valid),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata)
  );

endmodule

FILE: rtl/rrip_chk.sv
// Port-level checker for the RRIP replacement block, bound to the top level.
module rrip_chk (
  input logic       clk,
  input logic       rst,
  input logic       item_valid,
  input logic       item_stall,
  input logic       result_valid,
  input logic       result_stall,
  input logic [3:0] victim_way,
  input logic       victim_valid
);

  a_clear_after_reset: assert property (@(posedge clk) rst |=> item_stall)
    else $error("item_stall low right after reset");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall |=> item_stall)
    else $error("item accepted in two consecutive cycles");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid)
    else $error("stalled result dropped");

  a_way_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !victim_valid |-> victim_way == 4'd0)
    else $error("nonzero victim_way on a non-query result");

endmodule

bind rrip_cache_replacement_top rrip_chk u_chk (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_stall   (item_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .victim_way   (victim_way),
  .victim_valid (victim_valid)
);

FILE: tb/sv/rrip_replacement_checker.sv
// Checker for the RRIP replacement block: predicts each victim answer and compares results.
module rrip_replacement_checker #(
  parameter int SETS      = 64,
  parameter int WAYS      = 16,
  parameter int PRED_BITS = 3
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  input  logic        item_stall,
  input  logic [2:0]  command,
  input  logic [5:0]  set_index,
  input  logic [3:0]  way,
  input  logic        result_valid,
  input  logic        result_stall,
  input  logic [3:0]  victim_way,
  input  logic        victim_valid,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          fail_count,
  output int          pending,
  output int          results_checked,
  output int          queries_answered
);
  import rrip_pkg::*;

  localparam int DISTANT    = (1 << PRED_BITS) - 1;
  localparam int LONG_VALUE = DISTANT - 1;
  localparam int REPORT_MAX = 10;

  typedef struct packed {
    logic [3:0] way;
    logic       valid;
  } victim_answer_t;

  logic [PRED_BITS-1:0] rrpv [SETS][WAYS];
  logic [6:0]           period_reg;
  logic [6:0]           long_reg;
  int                   miss_pos;
  int                   long_cnt;
  victim_answer_t       victim_answers_due [$];
  int                   mismatches = 0;
  int                   checked = 0;
  int                   queries = 0;

  initial begin
    fail_count       = 0;
    pending          = 0;
    results_checked  = 0;
    queries_answered = 0;
  end

  function automatic int period_in_use();
    if (period_reg == 7'd0) return PERIOD_MIN;
    if (period_reg > PERIOD_MAX) return PERIOD_MAX;
    return period_reg;
  endfunction

  function automatic int long_in_use();
    return (long_reg > PERIOD_MAX) ? PERIOD_MAX : long_reg;
  endfunction

  // Value for the next miss fill; advances the insertion pattern.
  function automatic int take_insert_value();
    int p;
    int l;
    int v;
    p = period_in_use();
    l = long_in_use();
    if ((miss_pos + 1) * l > long_cnt * p) begin
      v = LONG_VALUE;
      long_cnt++;
    end else begin
      v = DISTANT;
    end
    miss_pos++;
    if (miss_pos >= p) begin
      miss_pos = 0;
      long_cnt = 0;
    end
    return v;
  endfunction

  function automatic victim_answer_t replay_event(logic [2:0] cmd, logic [5:0] s, logic [3:0] w);
    victim_answer_t ans;
    bit             set_ok;
    bit             way_ok;
    bit             found;
    int             d;
    int             v;
    int             k;
    int             best;
    int             maxv;
    ans    = '0;
    set_ok = s < SETS;
    way_ok = set_ok && (w < WAYS);
    case (cmd)
      CMD_HIT: begin
        if (way_ok) rrpv[s][w] = '0;
      end
      CMD_FILL: begin
        if (way_ok) rrpv[s][w] = PRED_BITS'(take_insert_value());
      end
      CMD_EVICT: begin
        if (way_ok) begin
          d = DISTANT - rrpv[s][w];
          for (k = 0; k < WAYS; k++) begin
            v = rrpv[s][k] + d;
            if (v > DISTANT) v = DISTANT;
            rrpv[s][k] = PRED_BITS'(v);
          end
        end
      end
      CMD_INVAL: begin
        if (way_ok) rrpv[s][w] = PRED_BITS'(DISTANT);
      end
      CMD_QUERY: begin
        ans.valid = 1'b1;
        if (set_ok) begin
          found = 1'b0;
          best  = 0;
          maxv  = 0;
          for (k = 0; k < WAYS; k++) begin
            if (!found) begin
              if (rrpv[s][k] == DISTANT) begin
                best  = k;
                found = 1'b1;
              end else if (rrpv[s][k] > maxv) begin
                maxv = rrpv[s][k];
                best = k;
              end
            end
          end
          ans.way = 4'(best);
        end
      end
      default: begin
      end
    endcase
    return ans;
  endfunction

  task automatic note_failure(string msg);
    mismatches++;
    if (mismatches <= REPORT_MAX) $display("checker: %s", msg);
  endtask

  always @(posedge clk) begin
    victim_answer_t due;
    reg_idx_t       idx;
    if (rst) begin
      for (int s = 0; s < SETS; s++) begin
        for (int w = 0; w < WAYS; w++) rrpv[s][w] = PRED_BITS'(DISTANT);
      end
      period_reg = PERIOD_RESET;
      long_reg   = LONG_RESET;
      miss_pos   = 0;
      long_cnt   = 0;
      victim_answers_due.delete();
    end else begin
      if (result_valid && !result_stall) begin
        if (victim_answers_due.size() == 0) begin
          note_failure($sformatf("result way %0d valid %0d with no item outstanding",
                                 victim_way, victim_valid));
        end else begin
          due = victim_answers_due.pop_front();
          checked++;
          if (due.valid) queries++;
          if (victim_way !== due.way || victim_valid !== due.valid) begin
            note_failure($sformatf("result %0d: expected way %0d valid %0d, got way %0d valid %0d",
                                   checked, due.way, due.valid, victim_way, victim_valid));
          end
        end
      end
      if (item_valid && !item_stall) begin
        victim_answers_due.push_back(replay_event(command, set_index, way));
      end
      if (psel && penable && pwrite && pready) begin
        idx = reg_idx_t'(paddr[2]);
        case (idx)
          REG_PERIOD: period_reg = pwdata[6:0];
          REG_LONG:   long_reg   = pwdata[6:0];
          default: begin
          end
        endcase
        miss_pos = 0;
        long_cnt = 0;
      end
    end
    pending          <= victim_answers_due.size();
    fail_count       <= mismatches;
    results_checked  <= checked;
    queries_answered <= queries;
  end

endmodule

FILE: tb/sv/tb_top.sv
// Testbench top for the RRIP replacement block: clock, reset, stimulus and verdict.
module tb_top;
  import rrip_pkg::*;

  localparam int         SETS           = 64;
  localparam int         WAYS           = 16;
  localparam int         PRED_BITS      = 3;
  localparam int         CYCLE_LIMIT    = 400000;
  localparam int         HOLD_CYCLES    = 300;
  localparam int         DRAIN_CYCLES   = 8;
  localparam logic [2:0] CMD_RSVD_FIRST = 3'd5;
  localparam logic [2:0] CMD_RSVD_LAST  = 3'd7;

  logic        clk = 1'b0;
  logic        rst;
  logic        item_valid;
  logic        item_stall;
  logic [2:0]  command;
  logic [5:0]  set_index;
  logic [3:0]  way;
  logic        result_valid;
  logic        result_stall;
  logic [3:0]  victim_way;
  logic        victim_valid;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int fail_count;
  int pending;
  int results_checked;
  int queries_answered;
  int items_sent = 0;
  int settings_used = 0;
  int cycle_count = 0;
  bit idle_free = 1'b0;
  bit hold_request = 1'b0;
  bit hold_done = 1'b0;
  logic [5:0] focus_sets [4] = '{6'd0, 6'd21, 6'd42, 6'd63};

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  rrip_cache_replacement_top #(
    .SETS(SETS), .WAYS(WAYS), .PRED_BITS(PRED_BITS)
  ) dut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall),
    .command(command), .set_index(set_index), .way(way),
    .result_valid(result_valid), .result_stall(result_stall),
    .victim_way(victim_way), .victim_valid(victim_valid),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  rrip_replacement_checker #(
    .SETS(SETS), .WAYS(WAYS), .PRED_BITS(PRED_BITS)
  ) u_checker (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall),
    .command(command), .set_index(set_index), .way(way),
    .result_valid(result_valid), .result_stall(result_stall),
    .victim_way(victim_way), .victim_valid(victim_valid),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready),
    .fail_count(fail_count), .pending(pending),
    .results_checked(results_checked), .queries_answered(queries_answered)
  );

  task automatic send_item(logic [2:0] c, logic [5:0] s, logic [3:0] w);
    int gap;
    gap = idle_free ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    command    <= c;
    set_index  <= s;
    way        <= w;
    do @(posedge clk); while (item_stall);
    items_sent++;
  endtask

  task automatic wait_all_answered();
    item_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_reg(reg_idx_t r, logic [6:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= {25'($urandom), value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(logic [6:0] period, logic [6:0] long_setting);
    wait_all_answered();
    write_reg(REG_PERIOD, period);
    write_reg(REG_LONG, long_setting);
    settings_used++;
  endtask

  function automatic logic [2:0] pick_command();
    int r;
    r = $urandom_range(0, 99);
    if (r < 25) return CMD_HIT;
    if (r < 50) return CMD_FILL;
    if (r < 65) return CMD_EVICT;
    if (r < 75) return CMD_INVAL;
    if (r < 95) return CMD_QUERY;
    return 3'($urandom_range(CMD_RSVD_FIRST, CMD_RSVD_LAST));
  endfunction

  function automatic logic [5:0] pick_set();
    if ($urandom_range(0, 3) == 0) return 6'($urandom);
    return focus_sets[$urandom_range(0, 3)];
  endfunction

  // Mostly whole-set fills and hit runs followed by queries, some bursts, a little noise.
  task automatic random_traffic(int count);
    int         sent;
    int         kind;
    logic [5:0] s;
    sent = 0;
    while (sent < count) begin
      kind = $urandom_range(0, 99);
      s    = pick_set();
      if (kind < 35) begin
        for (int w = 0; w < WAYS; w++) begin
          send_item(($urandom_range(0, 2) == 0) ? CMD_HIT : CMD_FILL, s, 4'(w));
        end
        send_item(CMD_QUERY, s, 4'($urandom));
        if ($urandom_range(0, 1) == 1) send_item(CMD_EVICT, s, 4'($urandom));
        send_item(CMD_QUERY, s, 4'($urandom));
        sent += WAYS + 3;
      end else if (kind < 85) begin
        repeat (10) send_item(pick_command(), s, 4'($urandom));
        sent += 10;
      end else begin
        send_item(3'($urandom), 6'($urandom), 4'($urandom));
        sent++;
      end
    end
  endtask

  initial begin
    result_stall <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      int lag;
      if (hold_request && !hold_done) begin
        result_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end
      lag = idle_free ? 0 : $urandom_range(0, 7);
      if (lag > 0) begin
        result_stall <= 1'b1;
        repeat (lag) @(posedge clk);
      end
      result_stall <= 1'b0;
      do @(posedge clk); while (!result_valid);
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("rrip_cache_replacement_top regression: fail");
    $finish;
  end

  initial begin
    rst        <= 1'b1;
    item_valid <= 1'b0;
    command    <= CMD_HIT;
    set_index  <= '0;
    way        <= '0;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= '0;
    pwdata     <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    settings_used = 1;

    // Directed items under the reset settings.
    send_item(CMD_QUERY, 6'd0, 4'd0);
    send_item(CMD_QUERY, 6'd63, 4'd15);
    send_item(CMD_HIT, 6'd63, 4'd15);
    send_item(CMD_HIT, 6'd63, 4'd0);
    send_item(CMD_QUERY, 6'd63, 4'd0);
    send_item(CMD_FILL, 6'd63, 4'd1);
    send_item(CMD_FILL, 6'd63, 4'd2);
    send_item(CMD_QUERY, 6'd63, 4'd7);
    send_item(CMD_INVAL, 6'd63, 4'd1);
    send_item(CMD_EVICT, 6'd63, 4'd1);
    send_item(CMD_HIT, 6'd63, 4'd1);
    send_item(CMD_EVICT, 6'd63, 4'd0);
    send_item(CMD_QUERY, 6'd63, 4'd0);
    send_item(CMD_FILL, 6'd63, 4'd3);
    send_item(CMD_EVICT, 6'd63, 4'd3);
    send_item(CMD_QUERY, 6'd63, 4'd3);
    send_item(CMD_RSVD_FIRST, 6'd63, 4'd15);
    send_item(CMD_RSVD_FIRST + 3'd1, 6'd0, 4'd0);
    send_item(CMD_RSVD_LAST, 6'd42, 4'd5);
    send_item(CMD_FILL, 6'd0, 4'd15);
    send_item(CMD_HIT, 6'd0, 4'd14);
    send_item(CMD_EVICT, 6'd0, 4'd14);
    send_item(CMD_QUERY, 6'd0, 4'd15);
    random_traffic(150);

    idle_free <= 1'b1;
    configure(7'd1, 7'd0);
    random_traffic(120);
    idle_free <= 1'b0;

    configure(7'd64, 7'd64);
    hold_request <= 1'b1;
    random_traffic(150);
    wait_all_answered();

    configure(7'd0, 7'd127);
    random_traffic(120);

    configure(7'd127, 7'd3);
    random_traffic(150);

    configure(7'd5, 7'd2);
    random_traffic(60);
    wait_all_answered();
    write_reg(REG_LONG, 7'd2);
    random_traffic(90);

    configure(7'd3, 7'd5);
    random_traffic(120);

    repeat (3) begin
      configure(7'($urandom_range(1, 64)), 7'($urandom_range(0, 64)));
      random_traffic(100);
    end

    wait_all_answered();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Summary: %0d items sent under %0d register settings.", items_sent, settings_used);
    $display("Summary: %0d results checked, %0d of them victim queries, %0d mismatches.",
             results_checked, queries_answered, fail_count);
    if (fail_count == 0) begin
      $display("rrip_cache_replacement_top regression: pass");
    end else begin
      $display("rrip_cache_replacement_top regression: fail");
    end
    $finish;
  end

endmodule
